/* sv/source_line_comment_depth_meter_core_assert.svh */
// Assertion macros shared by the comment depth meter RTL.
// Expects clk_i and rst_ni to be visible where a macro is used.
`ifndef SOURCE_LINE_COMMENT_DEPTH_METER_CORE_ASSERT_SVH
`define SOURCE_LINE_COMMENT_DEPTH_METER_CORE_ASSERT_SVH

// Checked on every rising edge outside of reset.
`define SLCDM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define SLCDM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* sv/slcdm_pkg.sv */
// Types, character codes and helper functions for the comment depth meter.
// No dependencies; used by the interfaces and the core.
`timescale 1ns / 1ps

package slcdm_pkg;

  localparam int unsigned OutCountWidth = 32;
  localparam int unsigned DepthWidth    = 16;
  localparam int unsigned DeepestWidth  = 15;
  localparam int unsigned LexWidth      = 3;

  localparam logic [7:0] ChLf        = 8'h0A;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChVt        = 8'h0B;
  localparam logic [7:0] ChFf        = 8'h0C;
  localparam logic [7:0] ChCr        = 8'h0D;
  localparam logic [7:0] ChSpace     = 8'h20;
  localparam logic [7:0] ChDquote    = 8'h22;
  localparam logic [7:0] ChSquote    = 8'h27;
  localparam logic [7:0] ChStar      = 8'h2A;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChLbrace    = 8'h7B;
  localparam logic [7:0] ChRbrace    = 8'h7D;

  localparam logic [LexWidth-1:0] LexCode  = 3'd0;
  localparam logic [LexWidth-1:0] LexLine  = 3'd1;
  localparam logic [LexWidth-1:0] LexBlock = 3'd2;
  localparam logic [LexWidth-1:0] LexStr   = 3'd3;
  localparam logic [LexWidth-1:0] LexChr   = 3'd4;

  localparam logic signed [DepthWidth-1:0] DepthMax = 16'sh7FFF;
  localparam logic signed [DepthWidth-1:0] DepthMin = 16'sh8000;

  typedef enum logic [4:0] {
    MODE_CODE  = 5'b00001,
    MODE_LINE  = 5'b00010,
    MODE_BLOCK = 5'b00100,
    MODE_STR   = 5'b01000,
    MODE_CHR   = 5'b10000
  } mode_e;

  function automatic logic is_text(input logic [7:0] c);
    return !(c == ChSpace || c == ChTab || c == ChLf || c == ChCr ||
             c == ChVt || c == ChFf);
  endfunction

  function automatic logic [LexWidth-1:0] lex_code(input mode_e m);
    logic [LexWidth-1:0] code;
    unique case (m)
      MODE_CODE:  code = LexCode;
      MODE_LINE:  code = LexLine;
      MODE_BLOCK: code = LexBlock;
      MODE_STR:   code = LexStr;
      MODE_CHR:   code = LexChr;
      default:    code = LexCode;
    endcase
    return code;
  endfunction

endpackage

/* sv/slcdm_if.sv */
// Valid/ready channel interfaces for the comment depth meter.
// Depends on slcdm_pkg for field widths.
`timescale 1ns / 1ps

interface slcdm_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink (input valid, input char_in, output ready);
endinterface

interface slcdm_result_if;
  logic                                          valid;
  logic                                          ready;
  logic [slcdm_pkg::OutCountWidth-1:0]           line_count;
  logic [slcdm_pkg::OutCountWidth-1:0]           blank_count;
  logic [slcdm_pkg::OutCountWidth-1:0]           comment_count;
  logic signed [slcdm_pkg::DepthWidth-1:0]       brace_depth;
  logic [slcdm_pkg::DeepestWidth-1:0]            deepest;
  logic [slcdm_pkg::LexWidth-1:0]                lex_mode;

  modport source (output valid, output line_count, output blank_count,
                  output comment_count, output brace_depth, output deepest,
                  output lex_mode, input ready);
  modport sink (input valid, input line_count, input blank_count,
                input comment_count, input brace_depth, input deepest,
                input lex_mode, output ready);
endinterface

/* sv/source_line_comment_depth_meter_core.sv */
// Comment depth meter core: lexical mode tracking, line, blank-segment and
// comment counters, brace depth. Depends on slcdm_pkg, slcdm_if.sv and the
// assertion macro header.
//
// Usage: one byte of C source enters per transfer on in_i (char_in). For each
// byte, exactly one result leaves on out_o carrying the running counts after
// that byte: line_count, blank_count, comment_count, brace_depth, deepest and
// the lexical mode code lex_mode.
// Latency: the result is valid on the cycle after the input transfer.
// Throughput: one byte per cycle while out_o.ready is high. The state
// registers themselves are the result register, so a new byte is taken
// in the same cycle that the previous result is taken by the receiver.
// Stall: while out_o.valid is high and out_o.ready is low the result holds
// and in_i.ready is low; no byte is taken until the result transfers.
// Reset: rst_ni low clears the mode to code, the line count to one, all
// other counts and the depth to zero, and drops out_o.valid.
// COUNT_WIDTH sets the internal counter width; the counters saturate at
// their maximum and the output fields carry the low 32 bits.
`timescale 1ns / 1ps
`include "source_line_comment_depth_meter_core_assert.svh"

module source_line_comment_depth_meter_core #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  slcdm_char_if.sink         in_i,
  slcdm_result_if.source     out_o
);

  localparam logic [COUNT_WIDTH-1:0] CountOne = COUNT_WIDTH'(1);
  localparam logic [COUNT_WIDTH-1:0] CountTop = {COUNT_WIDTH{1'b1}};

  slcdm_pkg::mode_e                          mode_q, mode_d;
  logic [7:0]                                prior_q;
  logic                                      seg_text_q, seg_text_d;
  logic [COUNT_WIDTH-1:0]                    lines_q, lines_d;
  logic [COUNT_WIDTH-1:0]                    blanks_q, blanks_d;
  logic [COUNT_WIDTH-1:0]                    comments_q, comments_d;
  logic signed [slcdm_pkg::DepthWidth-1:0]   depth_q, depth_d;
  logic [slcdm_pkg::DeepestWidth-1:0]        depth_max_q, depth_max_d;
  logic                                      out_valid_q;

  logic       in_fire;
  logic [7:0] c;
  logic       closed;
  logic       c_text;
  logic       prior_bs;

  assign in_fire  = in_i.valid && in_i.ready;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign c        = in_i.char_in;
  assign c_text   = slcdm_pkg::is_text(c);
  assign prior_bs = (prior_q == slcdm_pkg::ChBackslash);

  always_comb begin
    mode_d      = mode_q;
    lines_d     = lines_q;
    comments_d  = comments_q;
    depth_d     = depth_q;
    depth_max_d = depth_max_q;
    closed      = 1'b0;

    priority if (c == slcdm_pkg::ChLf) begin
      if (lines_q != CountTop) lines_d = lines_q + CountOne;
      closed = 1'b1;
      if (mode_q == slcdm_pkg::MODE_LINE) mode_d = slcdm_pkg::MODE_CODE;
    end else begin
      unique case (mode_q)
        slcdm_pkg::MODE_CODE: begin
          priority if (c == slcdm_pkg::ChDquote) begin
            closed = 1'b1;
            mode_d = slcdm_pkg::MODE_STR;
          end else if (c == slcdm_pkg::ChSquote) begin
            closed = 1'b1;
            mode_d = slcdm_pkg::MODE_CHR;
          end else if (prior_q == slcdm_pkg::ChSlash &&
                       (c == slcdm_pkg::ChSlash || c == slcdm_pkg::ChStar)) begin
            if (comments_q != CountTop) comments_d = comments_q + CountOne;
            closed = 1'b1;
            mode_d = (c == slcdm_pkg::ChSlash) ? slcdm_pkg::MODE_LINE
                                               : slcdm_pkg::MODE_BLOCK;
          end else if (c == slcdm_pkg::ChLbrace) begin
            if (depth_q != slcdm_pkg::DepthMax) depth_d = depth_q + 16'sd1;
            // A depth above the current maximum is always non-negative.
            if (depth_d > $signed({1'b0, depth_max_q})) begin
              depth_max_d = depth_d[slcdm_pkg::DeepestWidth-1:0];
            end
          end else if (c == slcdm_pkg::ChRbrace) begin
            if (depth_q != slcdm_pkg::DepthMin) depth_d = depth_q - 16'sd1;
          end else begin
            closed = 1'b0;
          end
        end
        slcdm_pkg::MODE_BLOCK: begin
          if (c == slcdm_pkg::ChSlash && prior_q == slcdm_pkg::ChStar) begin
            closed = 1'b1;
            mode_d = slcdm_pkg::MODE_CODE;
          end
        end
        slcdm_pkg::MODE_STR: begin
          if (c == slcdm_pkg::ChDquote && !prior_bs) begin
            closed = 1'b1;
            mode_d = slcdm_pkg::MODE_CODE;
          end
        end
        slcdm_pkg::MODE_CHR: begin
          if (c == slcdm_pkg::ChSquote && !prior_bs) begin
            closed = 1'b1;
            mode_d = slcdm_pkg::MODE_CODE;
          end
        end
        default: begin
          mode_d = mode_q;
        end
      endcase
    end

    // A closing byte ends the segment; it was blank if neither it nor any
    // earlier byte of the segment was text.
    blanks_d = blanks_q;
    if (closed) begin
      seg_text_d = 1'b0;
      if (!seg_text_q && !c_text && blanks_q != CountTop) begin
        blanks_d = blanks_q + CountOne;
      end
    end else begin
      seg_text_d = seg_text_q || c_text;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= slcdm_pkg::MODE_CODE;
      prior_q     <= 8'h00;
      seg_text_q  <= 1'b0;
      lines_q     <= CountOne;
      blanks_q    <= '0;
      comments_q  <= '0;
      depth_q     <= '0;
      depth_max_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        mode_q      <= mode_d;
        prior_q     <= c;
        seg_text_q  <= seg_text_d;
        lines_q     <= lines_d;
        blanks_q    <= blanks_d;
        comments_q  <= comments_d;
        depth_q     <= depth_d;
        depth_max_q <= depth_max_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  logic [63:0] lines_ext, blanks_ext, comments_ext;
  assign lines_ext    = 64'(lines_q);
  assign blanks_ext   = 64'(blanks_q);
  assign comments_ext = 64'(comments_q);

  assign out_o.valid         = out_valid_q;
  assign out_o.line_count    = lines_ext[slcdm_pkg::OutCountWidth-1:0];
  assign out_o.blank_count   = blanks_ext[slcdm_pkg::OutCountWidth-1:0];
  assign out_o.comment_count = comments_ext[slcdm_pkg::OutCountWidth-1:0];
  assign out_o.brace_depth   = depth_q;
  assign out_o.deepest       = depth_max_q;
  assign out_o.lex_mode      = slcdm_pkg::lex_code(mode_q);

  // A newline transfer always advances the line count unless it is saturated.
  `SLCDM_ASSERT(a_newline_counts, (in_fire && c == slcdm_pkg::ChLf) |=> (lines_q == $past(lines_q) + CountOne || lines_q == CountTop), "newline did not advance line count")

  // A non-negative depth never exceeds the recorded maximum.
  `SLCDM_ASSERT(a_deepest_bound, (depth_q[slcdm_pkg::DepthWidth-1] || depth_q[slcdm_pkg::DeepestWidth-1:0] <= depth_max_q), "brace depth above deepest")

  // Comments are only counted on a slash or star byte.
  `SLCDM_ASSERT(a_comment_only_on_opener, (in_fire && c != slcdm_pkg::ChSlash && c != slcdm_pkg::ChStar) |=> $stable(comments_q), "comment count moved without opener")

  // State only moves on an input transfer.
  `SLCDM_ASSERT(a_state_holds, !in_fire |=> ($stable(lines_q) && $stable(mode_q) && $stable(depth_q)), "state changed without transfer")

endmodule
